// ===== hw/rtl/osss_pkg.sv =====
// Package for the ordered small set store: sizes, command codes and the
// transaction structs. No dependencies.
package osss_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W       = 8;
  localparam int CAP_W       = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [KEY_W-1:0] key;
    logic [3:0]       index;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic             changed;
    logic [4:0]       count;
    logic [KEY_W-1:0] entry_value;
    logic             index_ok;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [KEY_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// ===== hw/rtl/osss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module osss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/osss_engine.sv =====
// Sequencer for the set store: scans, appends and compacts entries through one
// RAM port pair, one entry per cycle, with a single key comparator. Uses osss_pkg.
module osss_engine (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  osss_pkg::in_item_t              start_item,
  input  logic [osss_pkg::CAP_W-1:0]      cap,
  input  logic                            take,
  input  logic [osss_pkg::KEY_W-1:0]      rdata,
  output osss_pkg::ram_req_t              ram_req,
  output logic                            idle,
  output logic                            done,
  output osss_pkg::out_item_t             result
);
  import osss_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_SHIFT  = 5'b00100,
    ST_RDWAIT = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  localparam int CMP_W = CNT_W + CAP_W;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [ADDR_W-1:0] cmp_r, cmp_nxt;
  logic              rv_r, rv_nxt;
  in_item_t          item_r, item_nxt;
  out_item_t         res_r, res_nxt;

  logic issue, hit, room, last;

  assign issue = ptr_r < cnt_r;
  assign hit   = rv_r && (rdata == item_r.key);
  assign room  = (CMP_W'(cnt_r) < CMP_W'(cap)) && (cnt_r < CNT_W'(MAX_ENTRIES));
  assign last  = (CNT_W'(cmp_r) + CNT_W'(1)) == cnt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    cmp_nxt   = cmp_r;
    rv_nxt    = 1'b0;
    item_nxt  = item_r;
    res_nxt   = res_r;
    ram_req   = '0;
    ram_req.raddr = ptr_r[ADDR_W-1:0];

    case (state_r)
      ST_IDLE: begin
        ram_req.raddr = ADDR_W'(start_item.index);
        if (start) begin
          item_nxt = start_item;
          res_nxt  = '0;
          ptr_nxt  = '0;
          if (start_item.cmd == CMD_READ) begin
            if (CMP_W'(start_item.index) < CMP_W'(cnt_r)) begin
              state_nxt = ST_RDWAIT;
            end else begin
              state_nxt = ST_DONE;
            end
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          ptr_nxt = ptr_r + CNT_W'(1);
          rv_nxt  = 1'b1;
          cmp_nxt = ptr_r[ADDR_W-1:0];
        end
        if (hit) begin
          res_nxt.found = 1'b1;
          rv_nxt        = 1'b0;
          if (item_r.cmd == CMD_DELETE) begin
            if (last) begin
              cnt_nxt           = cnt_r - CNT_W'(1);
              res_nxt.changed   = 1'b1;
              state_nxt         = ST_DONE;
            end else begin
              ptr_nxt   = CNT_W'(cmp_r) + CNT_W'(1);
              state_nxt = ST_SHIFT;
            end
          end else begin
            state_nxt = ST_DONE;
          end
        end else if (!rv_r && !issue) begin
          if (item_r.cmd == CMD_ADD && room) begin
            ram_req.we      = 1'b1;
            ram_req.waddr   = cnt_r[ADDR_W-1:0];
            ram_req.wdata   = item_r.key;
            cnt_nxt         = cnt_r + CNT_W'(1);
            res_nxt.changed = 1'b1;
          end
          state_nxt = ST_DONE;
        end
      end
      ST_SHIFT: begin
        if (issue) begin
          ptr_nxt = ptr_r + CNT_W'(1);
          rv_nxt  = 1'b1;
          cmp_nxt = ptr_r[ADDR_W-1:0];
        end
        if (rv_r) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = cmp_r - ADDR_W'(1);
          ram_req.wdata = rdata;
        end else if (!issue) begin
          cnt_nxt         = cnt_r - CNT_W'(1);
          res_nxt.changed = 1'b1;
          state_nxt       = ST_DONE;
        end
      end
      ST_RDWAIT: begin
        res_nxt.entry_value = rdata;
        res_nxt.index_ok    = 1'b1;
        state_nxt           = ST_DONE;
      end
      ST_DONE: begin
        if (take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rv_r    <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    cmp_r  <= cmp_nxt;
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign idle = (state_r == ST_IDLE);
  assign done = (state_r == ST_DONE);

  always_comb begin
    result       = res_r;
    result.count = 5'(cnt_r);
  end

endmodule

// ===== hw/rtl/ordered_small_set_store_unit.sv =====
// Ordered small set store. A read fetches the entry at its index, or skips the
// RAM at or beyond count; add, query and delete scan the entries in order up to
// a hit or the set's end; a delete of any but the last entry compacts the rest.
// One transaction at a time: the next is accepted the cycle after the result is
// registered, or after a stalled output register frees. Synchronous active-low
// reset empties the set and sets capacity to 16; entry storage is not cleared.
module ordered_small_set_store_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  osss_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output osss_pkg::out_item_t         out_data,
  input  logic                        cfg_wr_en,
  input  logic [osss_pkg::CAP_W-1:0]  cfg_wr_data
);
  import osss_pkg::*;

  logic [CAP_W-1:0] cap_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  ram_req_t         ram_req;
  logic [KEY_W-1:0] rdata;
  logic             eng_idle, eng_done, take, start;
  out_item_t        eng_result;

  assign in_stall = !eng_idle;
  assign start    = in_valid && eng_idle;
  assign take     = eng_done && (!out_valid_r || !out_stall);

  osss_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (rdata)
  );

  osss_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .start_item (in_data),
    .cap        (cap_r),
    .take       (take),
    .rdata      (rdata),
    .ram_req    (ram_req),
    .idle       (eng_idle),
    .done       (eng_done),
    .result     (eng_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= eng_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/osss_checker.sv =====
// Port-level checks for ordered_small_set_store_unit, bound to the top level.
// Uses osss_pkg.
module osss_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input osss_pkg::out_item_t out_data
);
  import osss_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.count <= 5'(MAX_ENTRIES)))
    else $error("count beyond set size");

  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.index_ok |-> !out_data.found && !out_data.changed)
    else $error("read result with set flags");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.index_ok |-> (out_data.entry_value == '0))
    else $error("entry value without valid index");

endmodule

bind ordered_small_set_store_unit osss_checker u_osss_checker (.*);

// ===== bench/osss_checker.sv =====
`timescale 1ns / 100ps
// Checker for the ordered small set store: follows the input, result and capacity
// ports, predicts each result transaction and compares it. Depends on osss_pkg.
module osss_set_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  osss_pkg::in_item_t         in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  osss_pkg::out_item_t        out_data,
  input  logic                       cfg_wr_en,
  input  logic [osss_pkg::CAP_W-1:0] cfg_wr_data,
  output int                         errors,
  output int                         pending
);
  import osss_pkg::*;

  logic [KEY_W-1:0] set_keys [MAX_ENTRIES];
  int               set_size;
  logic [CAP_W-1:0] cap_value;
  out_item_t        expected_q [$];
  out_item_t        want;
  int               miss_n;

  function automatic out_item_t apply_set_command(in_item_t t);
    out_item_t r;
    int pos;
    int i;
    int cap_eff;
    logic hit;
    r = '0;
    pos = set_size;
    for (i = 0; i < set_size; i++)
      if (pos == set_size && set_keys[i] == t.key) pos = i;
    hit = (pos < set_size);
    cap_eff = (cap_value > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_value);
    case (t.cmd)
      CMD_ADD: begin
        r.found = hit;
        if (!hit && set_size < cap_eff) begin
          set_keys[set_size] = t.key;
          set_size++;
          r.changed = 1'b1;
        end
      end
      CMD_DELETE: begin
        r.found = hit;
        if (hit) begin
          for (i = pos + 1; i < set_size; i++) set_keys[i-1] = set_keys[i];
          set_size--;
          r.changed = 1'b1;
        end
      end
      CMD_QUERY: begin
        r.found = hit;
      end
      default: begin
        if (int'(t.index) < set_size) begin
          r.entry_value = set_keys[t.index];
          r.index_ok = 1'b1;
        end
      end
    endcase
    r.count = 5'(set_size);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      set_size = 0;
      cap_value = CAP_RESET;
      expected_q.delete();
      miss_n = 0;
      pending <= 0;
      errors <= 0;
    end else begin
      if (cfg_wr_en) cap_value = cfg_wr_data;
      if (in_valid && !in_stall) expected_q.push_back(apply_set_command(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          miss_n++;
          if (miss_n <= 10) $display("%0t: result transaction with none expected: %p", $time,
                                     out_data);
        end else begin
          want = expected_q.pop_front();
          if (out_data.found !== want.found || out_data.changed !== want.changed ||
              out_data.count !== want.count || out_data.entry_value !== want.entry_value ||
              out_data.index_ok !== want.index_ok) begin
            miss_n++;
            if (miss_n <= 10)
              $display("%0t: mismatch exp found=%0d changed=%0d count=%0d value=%02h ok=%0d",
                       $time, want.found, want.changed, want.count, want.entry_value,
                       want.index_ok, " / got found=%0d changed=%0d count=%0d value=%02h ok=%0d",
                       out_data.found, out_data.changed, out_data.count,
                       out_data.entry_value, out_data.index_ok);
          end
        end
      end
      pending <= expected_q.size();
      errors <= miss_n;
    end
  end

endmodule

// ===== bench/ordered_small_set_store_unit_tb.sv =====
`timescale 1ns / 100ps
// Top of the ordered small set store bench: clock, reset, command and capacity
// stimulus, result-side stall pattern and verdict. Depends on osss_pkg, the unit
// and osss_set_checker.
module ordered_small_set_store_unit_tb;
  import osss_pkg::*;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;
  int               errors;
  int               pending;

  ordered_small_set_store_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  osss_set_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_cmd(input cmd_t c, input logic [KEY_W-1:0] k, input logic [3:0] idx);
    in_data.cmd = c;
    in_data.key = k;
    in_data.index = idx;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] v);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic run_phase(input int n, input int pool_n);
    logic [KEY_W-1:0] pool [24];
    int sent;
    int burst;
    int gap;
    int roll;
    cmd_t c;
    logic [KEY_W-1:0] k;
    sent = 0;
    foreach (pool[i]) pool[i] = 8'($urandom);
    while (sent < n) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && sent < n; b++) begin
        roll = $urandom_range(0, 99);
        if (roll < 40) c = CMD_ADD;
        else if (roll < 65) c = CMD_DELETE;
        else if (roll < 80) c = CMD_QUERY;
        else c = CMD_READ;
        if ($urandom_range(0, 9) == 0) k = 8'($urandom);
        else k = pool[$urandom_range(0, pool_n - 1)];
        send_cmd(c, k, 4'($urandom_range(0, 15)));
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // result side: mixed stall segments, with occasional long hold-offs
  initial begin
    int segs;
    int kind;
    int len;
    out_stall = 1'b0;
    segs = 0;
    wait (rst_n === 1'b1);
    forever begin
      segs++;
      if (segs == 4 || $urandom_range(0, 49) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(150, 250)) @(negedge clk);
      end else begin
        kind = $urandom_range(0, 3);
        len = $urandom_range(1, 40);
        repeat (len) begin
          case (kind)
            0: out_stall = 1'b0;
            1: out_stall = ($urandom_range(0, 1) == 0);
            2: out_stall = ($urandom_range(0, 3) == 0);
            default: out_stall = ($urandom_range(0, 3) != 0);
          endcase
          @(negedge clk);
        end
      end
    end
  end

  initial begin
    int caps [10];
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    caps = '{16, 31, 5, 0, 1, 16, 12, 2, 20, 16};
    caps[8] = $urandom_range(1, 16);
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // empty set, duplicates, reads in and beyond range, compaction
    send_cmd(CMD_READ,   8'h00, 4'd0);
    send_cmd(CMD_QUERY,  8'h00, 4'd0);
    send_cmd(CMD_DELETE, 8'hFF, 4'd0);
    send_cmd(CMD_ADD,    8'h00, 4'd0);
    send_cmd(CMD_ADD,    8'hFF, 4'd15);
    send_cmd(CMD_ADD,    8'hFF, 4'd0);
    send_cmd(CMD_ADD,    8'h5A, 4'd0);
    send_cmd(CMD_ADD,    8'hA5, 4'd0);
    send_cmd(CMD_QUERY,  8'hFF, 4'd0);
    send_cmd(CMD_READ,   8'h00, 4'd0);
    send_cmd(CMD_READ,   8'hFF, 4'd3);
    send_cmd(CMD_READ,   8'h00, 4'd4);
    send_cmd(CMD_READ,   8'h00, 4'd15);
    send_cmd(CMD_DELETE, 8'h00, 4'd0);
    send_cmd(CMD_DELETE, 8'hA5, 4'd0);
    send_cmd(CMD_READ,   8'h00, 4'd1);
    // capacity below the count held, then full at one
    set_capacity(5'd1);
    send_cmd(CMD_ADD,    8'h11, 4'd0);
    send_cmd(CMD_DELETE, 8'hFF, 4'd0);
    send_cmd(CMD_ADD,    8'h11, 4'd0);
    send_cmd(CMD_DELETE, 8'h5A, 4'd0);
    send_cmd(CMD_ADD,    8'h11, 4'd0);
    set_capacity(5'd0);
    send_cmd(CMD_ADD,    8'h22, 4'd0);
    send_cmd(CMD_DELETE, 8'h11, 4'd0);
    send_cmd(CMD_ADD,    8'h33, 4'd0);
    set_capacity(5'd31);
    send_cmd(CMD_ADD,    8'h77, 4'd0);

    foreach (caps[p]) begin
      set_capacity(5'(caps[p]));
      run_phase(123, (caps[p] >= 12) ? 24 : 8);
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (errors == 0 && pending == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== ordered_small_set_store_unit.f =====
hw/rtl/osss_pkg.sv
hw/rtl/osss_ram.sv
hw/rtl/osss_engine.sv
hw/rtl/ordered_small_set_store_unit.sv
hw/rtl/osss_checker.sv
bench/osss_checker.sv
bench/ordered_small_set_store_unit_tb.sv
